// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; each expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define EFR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define EFR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- hw/rtl/efr_pkg.sv -----
`default_nettype none

package efr_pkg;

  localparam int MAX_EPC_BYTES_DEF = 31;
  localparam int HEADER_LEN        = 16;
  localparam int HDR_MATCH_LEN     = 4;
  localparam int LEN_HI_POS        = 14;
  localparam int LEN_LO_POS        = 15;
  localparam int TIMEOUT_W         = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] HDR_CHR_0 = 8'h34;
  localparam logic [7:0] HDR_CHR_1 = 8'h30;
  localparam logic [7:0] HDR_CHR_2 = 8'h30;
  localparam logic [7:0] HDR_CHR_3 = 8'h31;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_BUSY = 2'd2,
    REQ_LINK = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_READ = 2'd1,
    CS_LOAD = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic in_ready;
    logic load_out;
    logic adv_idx;
  } efr_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic last_idx;
    logic out_free;
  } efr_status_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/efr_if.sv -----
`default_nettype none

interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       flag_value;

  modport source (output valid, req_type, data_byte, flag_value, input ready);
  modport sink (input valid, req_type, data_byte, flag_value, output ready);
endinterface

interface efr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] epc_char;
  logic       last_char;

  modport source (output valid, epc_char, last_char, input ready);
  modport sink (input valid, epc_char, last_char, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/efr_ctrl.sv -----
`default_nettype none

module efr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  efr_pkg::efr_status_t status,
  output efr_pkg::efr_cmd_t    cmd
);

  efr_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efr_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      efr_pkg::CS_IDLE: begin
        if (status.frame_done) state_next = efr_pkg::CS_READ;
      end
      efr_pkg::CS_READ: begin
        state_next = efr_pkg::CS_LOAD;
      end
      efr_pkg::CS_LOAD: begin
        if (status.out_free) begin
          state_next = status.last_idx ? efr_pkg::CS_IDLE : efr_pkg::CS_READ;
        end
      end
      default: begin
        state_next = efr_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      efr_pkg::CS_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      efr_pkg::CS_LOAD: begin
        cmd.load_out = status.out_free;
        cmd.adv_idx  = status.out_free && !status.last_idx;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/efr_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

module efr_datapath #(
  parameter int MAX_EPC_BYTES = efr_pkg::MAX_EPC_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  efr_in_if.sink               in_ch,
  efr_out_if.source            out_ch,
  input  efr_pkg::efr_cmd_t    cmd,
  output efr_pkg::efr_status_t status
);

  localparam int STORE_DEPTH = 2 * MAX_EPC_BYTES;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(efr_pkg::HEADER_LEN + STORE_DEPTH + 2);
  localparam int CMP_W       = (COUNT_W > 9) ? COUNT_W : 9;
  localparam int TW          = efr_pkg::TIMEOUT_W;

  logic [TW-1:0]      timeout_ticks;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               header_matched, header_matched_next;
  logic [7:0]         header_bytes [3];
  logic [7:0]         length_hi_char, length_hi_char_next;
  logic [7:0]         payload_length, payload_length_next;
  logic               cr_seen, cr_seen_next;
  logic [TW-1:0]      timeout_left, timeout_left_next;
  logic               busy_flag, busy_flag_next;
  logic               link_enable, link_enable_next;

  logic [7:0]        store [STORE_DEPTH];
  logic [7:0]        store_rdata;
  logic              store_we;
  logic [ADDR_W-1:0] store_waddr;
  logic              hdr_we;

  logic [ADDR_W-1:0] rd_idx;
  logic [ADDR_W-1:0] emit_last, emit_last_next;
  logic              emit_set;

  logic       out_valid;
  logic [7:0] out_data;
  logic       out_last;

  logic       fire;
  logic [7:0] b;

  assign in_ch.ready = cmd.in_ready;
  assign fire        = in_ch.valid && cmd.in_ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    logic             clear_req;
    logic [CMP_W-1:0] off;
    logic [CMP_W-1:0] nchar;
    logic [4:0]       hi;
    logic [4:0]       lo;
    logic [7:0]       len;

    byte_count_next     = byte_count;
    header_matched_next = header_matched;
    length_hi_char_next = length_hi_char;
    payload_length_next = payload_length;
    cr_seen_next        = cr_seen;
    timeout_left_next   = timeout_left;
    busy_flag_next      = busy_flag;
    link_enable_next    = link_enable;
    store_we            = 1'b0;
    hdr_we              = 1'b0;
    emit_set            = 1'b0;
    clear_req           = 1'b0;

    off   = CMP_W'(byte_count) - CMP_W'(efr_pkg::HEADER_LEN);
    nchar = CMP_W'({payload_length, 1'b0});
    hi    = efr_pkg::hex_digit(length_hi_char);
    lo    = efr_pkg::hex_digit(b);
    len   = (hi[4] && lo[4]) ? {hi[3:0], lo[3:0]} : 8'd0;

    store_waddr    = off[ADDR_W-1:0];
    emit_last_next = ADDR_W'(nchar - CMP_W'(1));

    if (fire) begin
      case (efr_pkg::req_t'(in_ch.req_type))
        efr_pkg::REQ_BYTE: begin
          if (link_enable) begin
            if (busy_flag) begin
              clear_req = 1'b1;
            end else if (byte_count < COUNT_W'(efr_pkg::HDR_MATCH_LEN)) begin
              byte_count_next = byte_count + COUNT_W'(1);
              if (byte_count == COUNT_W'(efr_pkg::HDR_MATCH_LEN - 1)) begin
                if (header_bytes[0] == efr_pkg::HDR_CHR_0 &&
                    header_bytes[1] == efr_pkg::HDR_CHR_1 &&
                    header_bytes[2] == efr_pkg::HDR_CHR_2 &&
                    b == efr_pkg::HDR_CHR_3) begin
                  header_matched_next = 1'b1;
                  timeout_left_next   = timeout_ticks;
                end else begin
                  clear_req = 1'b1;
                end
              end else begin
                hdr_we = 1'b1;
              end
            end else if (byte_count < COUNT_W'(efr_pkg::HEADER_LEN)) begin
              byte_count_next = byte_count + COUNT_W'(1);
              if (byte_count == COUNT_W'(efr_pkg::LEN_HI_POS)) begin
                length_hi_char_next = b;
              end
              if (byte_count == COUNT_W'(efr_pkg::LEN_LO_POS)) begin
                if (int'(len) > MAX_EPC_BYTES) begin
                  clear_req = 1'b1;
                end else begin
                  payload_length_next = len;
                end
              end
            end else if (off < nchar) begin
              store_we        = 1'b1;
              byte_count_next = byte_count + COUNT_W'(1);
            end else if (off == nchar) begin
              cr_seen_next    = (b == efr_pkg::CHR_CR);
              byte_count_next = byte_count + COUNT_W'(1);
            end else begin
              if (cr_seen && b == efr_pkg::CHR_LF) begin
                busy_flag_next = 1'b1;
                emit_set       = (nchar != '0);
              end
              clear_req = 1'b1;
            end
          end
        end
        efr_pkg::REQ_TICK: begin
          if (header_matched) begin
            if (timeout_left <= TW'(1)) begin
              clear_req = 1'b1;
            end else begin
              timeout_left_next = timeout_left - TW'(1);
            end
          end
        end
        efr_pkg::REQ_BUSY: begin
          busy_flag_next = in_ch.flag_value;
        end
        efr_pkg::REQ_LINK: begin
          link_enable_next = in_ch.flag_value;
        end
        default: begin
          clear_req = 1'b0;
        end
      endcase
    end

    if (clear_req) begin
      byte_count_next     = '0;
      header_matched_next = 1'b0;
      length_hi_char_next = '0;
      payload_length_next = '0;
      cr_seen_next        = 1'b0;
      timeout_left_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= efr_pkg::TIMEOUT_RESET;
      byte_count     <= '0;
      header_matched <= 1'b0;
      length_hi_char <= '0;
      payload_length <= '0;
      cr_seen        <= 1'b0;
      timeout_left   <= '0;
      busy_flag      <= 1'b0;
      link_enable    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) timeout_ticks <= cfg_wdata;
      byte_count     <= byte_count_next;
      header_matched <= header_matched_next;
      length_hi_char <= length_hi_char_next;
      payload_length <= payload_length_next;
      cr_seen        <= cr_seen_next;
      timeout_left   <= timeout_left_next;
      busy_flag      <= busy_flag_next;
      link_enable    <= link_enable_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) header_bytes[byte_count[1:0]] <= b;
    if (store_we) store[store_waddr] <= b;
    store_rdata <= store[rd_idx];
    if (emit_set) begin
      rd_idx    <= '0;
      emit_last <= emit_last_next;
    end else if (cmd.adv_idx) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
    if (cmd.load_out) begin
      out_data <= store_rdata;
      out_last <= (rd_idx == emit_last);
    end
  end

  assign status.frame_done = emit_set;
  assign status.last_idx   = (rd_idx == emit_last);
  assign status.out_free   = !out_valid || out_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.epc_char  = out_data;
  assign out_ch.last_char = out_last;

  `EFR_ASSERT_NEXT(a_done_sets_busy, emit_set, busy_flag, "good frame did not set busy")
  `EFR_ASSERT_ALWAYS(a_match_count, header_matched == (byte_count >= COUNT_W'(efr_pkg::HDR_MATCH_LEN)), "header match and byte count disagree")
  `EFR_ASSERT_ALWAYS(a_len_range, int'(payload_length) <= MAX_EPC_BYTES, "payload length above limit")
  `EFR_ASSERT_ALWAYS(a_no_write_emit, !(store_we && !cmd.in_ready), "store written during emit")

endmodule

`default_nettype wire

// ----- hw/rtl/epc_frame_receiver_top.sv -----
`default_nettype none

// ASCII frame receiver. Each input beat is a received byte, a timer tick, a busy
// flag write or a link-enable write; input is taken one beat per cycle while the
// controller is idle. A frame is 16 header bytes starting "4001" with a
// two-hex-digit length L in bytes 14-15, then 2L payload characters and CR LF.
// When the LF of a good frame is taken, the busy flag is set and input holds off
// while the 2L characters go out, one beat each, last_char marking the final one;
// each character passes through the payload store's registered read, then the
// output register load, and any output stall lengthens the emit run. The result
// register lets the next input beat in while the final character still waits.
// Clear busy with a busy flag write before the next frame.

module epc_frame_receiver_top #(
  parameter int MAX_EPC_BYTES = efr_pkg::MAX_EPC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  efr_in_if.sink      in_ch,
  efr_out_if.source   out_ch
);

  efr_pkg::efr_cmd_t    cmd;
  efr_pkg::efr_status_t status;

  efr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  efr_datapath #(
    .MAX_EPC_BYTES (MAX_EPC_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ----- sim/tb_epc_frame_receiver_top.sv -----
`timescale 1ns / 100ps

module tb_epc_frame_receiver_top;
  import efr_pkg::*;

  localparam int MAX_LEN       = MAX_EPC_BYTES_DEF;
  localparam int MAX_CHARS     = 2 * MAX_LEN;
  localparam int SETTLE_CYCLES = 4 * MAX_LEN + 16;
  localparam int RANDOM_ITEMS  = 24;
  localparam int TICK_ODDS     = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } epc_beat_t;

  typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_HEX, FLAW_TRAILER} frame_flaw_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  efr_in_if  in_ch ();
  efr_out_if out_ch ();

  epc_frame_receiver_top uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // receiver state as predicted
  int          rx_count;
  logic        rx_matched;
  logic [7:0]  rx_hdr [4];
  logic [7:0]  rx_len_hi;
  int          rx_len;
  logic [7:0]  rx_store [MAX_CHARS];
  logic        rx_cr;
  logic [15:0] rx_left;
  logic        rx_busy;
  logic        rx_link;
  logic [15:0] rx_timeout;

  epc_beat_t pending_chars [$];

  int   items_sent;
  int   chars_checked;
  int   frames_emitted;
  int   mismatches;
  bit   no_gaps;
  bit   hold_req;
  int   hold_len;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_epc_frame_receiver_top failed");
    $finish;
  end

  function automatic void clear_frame();
    rx_count   = 0;
    rx_matched = 1'b0;
    rx_len_hi  = 8'h00;
    rx_len     = 0;
    rx_cr      = 1'b0;
    rx_left    = 16'd0;
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'(int'("0") + v);
    if ($urandom_range(0, 1) == 0) return 8'(int'("A") + v - 10);
    return 8'(int'("a") + v - 10);
  endfunction

  task automatic predict_item(input req_t req, input logic [7:0] b, input logic f);
    int        pos;
    int        hi;
    int        lo;
    int        len;
    int        nchar;
    int        off;
    epc_beat_t beat;
    pos = rx_count;
    case (req)
      REQ_BYTE: begin
        if (!rx_link) begin
        end else if (rx_busy) begin
          clear_frame();
        end else if (pos < HDR_MATCH_LEN) begin
          rx_hdr[pos] = b;
          rx_count = pos + 1;
          if (pos == HDR_MATCH_LEN - 1) begin
            if (rx_hdr[0] == HDR_CHR_0 && rx_hdr[1] == HDR_CHR_1 &&
                rx_hdr[2] == HDR_CHR_2 && rx_hdr[3] == HDR_CHR_3) begin
              rx_matched = 1'b1;
              rx_left = rx_timeout;
            end else begin
              clear_frame();
            end
          end
        end else if (pos < HEADER_LEN) begin
          if (pos == LEN_HI_POS) rx_len_hi = b;
          rx_count = pos + 1;
          if (pos == LEN_LO_POS) begin
            hi = hex_val(rx_len_hi);
            lo = hex_val(b);
            len = (hi < 0 || lo < 0) ? 0 : hi * 16 + lo;
            if (len > MAX_LEN) clear_frame();
            else rx_len = len;
          end
        end else begin
          nchar = 2 * rx_len;
          off = pos - HEADER_LEN;
          if (off < nchar) begin
            rx_store[off] = b;
            rx_count = pos + 1;
          end else if (off == nchar) begin
            rx_cr = (b == CHR_CR);
            rx_count = pos + 1;
          end else if (rx_cr && b == CHR_LF) begin
            for (int k = 0; k < nchar; k++) begin
              beat.ch = rx_store[k];
              beat.last = (k == nchar - 1);
              pending_chars.push_back(beat);
            end
            frames_emitted++;
            rx_busy = 1'b1;
            clear_frame();
          end else begin
            clear_frame();
          end
        end
      end
      REQ_TICK: begin
        if (rx_matched) begin
          if (rx_left <= 16'd1) clear_frame();
          else rx_left = rx_left - 16'd1;
        end
      end
      REQ_BUSY: rx_busy = f;
      default:  rx_link = f;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    epc_beat_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch("unexpected epc_char", -1, out_ch.epc_char);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_ch.epc_char !== want.ch) flag_mismatch("epc_char", want.ch, out_ch.epc_char);
        if (out_ch.last_char !== want.last) begin
          flag_mismatch("last_char", want.last, out_ch.last_char);
        end
      end
    end
  end

  initial begin : sink_driver
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_ch.valid === 1'b1 || hold_req) break;
      end
    end
  end

  task automatic send_item(input req_t req, input logic [7:0] data, input logic flag);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.data_byte  <= data;
    in_ch.flag_value <= flag;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_item(req, data, flag);
    items_sent++;
  endtask

  task automatic send_frame(input int len_val, input frame_flaw_t flaw, input int tick_odds,
                            input bit extremes);
    logic [7:0] bytes [$];
    logic [7:0] len_code;
    logic [7:0] c;
    logic [7:0] t0;
    logic [7:0] t1;
    int         pick;
    int         n_payload;
    len_code = len_val[7:0];
    bytes = {HDR_CHR_0, HDR_CHR_1, HDR_CHR_2, HDR_CHR_3};
    if (flaw == FLAW_HEADER) begin
      pick = $urandom_range(0, 3);
      do c = 8'($urandom); while (c == bytes[pick]);
      bytes[pick] = c;
    end
    repeat (LEN_HI_POS - HDR_MATCH_LEN) bytes.push_back(8'($urandom));
    bytes.push_back(hex_char(len_code[7:4]));
    bytes.push_back(hex_char(len_code[3:0]));
    if (flaw == FLAW_HEX) begin
      pick = $urandom_range(LEN_HI_POS, LEN_LO_POS);
      do c = 8'($urandom); while (hex_val(c) >= 0);
      bytes[pick] = c;
    end
    n_payload = (flaw == FLAW_HEX || len_val > MAX_LEN) ? 0 : 2 * len_val;
    for (int k = 0; k < n_payload; k++) begin
      bytes.push_back(extremes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom));
    end
    if (len_val <= MAX_LEN || flaw == FLAW_HEX) begin
      t0 = CHR_CR;
      t1 = CHR_LF;
      if (flaw == FLAW_TRAILER) begin
        do begin
          pick = $urandom_range(0, 2);
          t0 = (pick == 0) ? CHR_CR : (pick == 1) ? CHR_LF : 8'($urandom);
          pick = $urandom_range(0, 2);
          t1 = (pick == 0) ? CHR_CR : (pick == 1) ? CHR_LF : 8'($urandom);
        end while (t0 == CHR_CR && t1 == CHR_LF);
      end
      bytes.push_back(t0);
      bytes.push_back(t1);
    end
    foreach (bytes[i]) begin
      send_item(REQ_BYTE, bytes[i], 1'($urandom));
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) begin
        send_item(REQ_TICK, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    go_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rx_timeout = value;
  endtask

  task automatic test_good_frame();
    send_item(REQ_LINK, 8'h00, 1'b1);
    send_frame(1, FLAW_NONE, 0, 1'b1);
    send_item(REQ_BUSY, 8'hFF, 1'b0);
  endtask

  task automatic test_link_down();
    send_item(REQ_LINK, 8'h5A, 1'b0);
    send_item(REQ_BYTE, HDR_CHR_0, 1'b1);
    send_item(REQ_TICK, 8'hA5, 1'b0);
    send_item(REQ_LINK, 8'h00, 1'b1);
  endtask

  task automatic test_busy_byte();
    send_item(REQ_BYTE, HDR_CHR_0, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b1);
    send_item(REQ_BYTE, HDR_CHR_1, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b0);
  endtask

  task automatic test_bad_header();
    send_item(REQ_BYTE, HDR_CHR_0, 1'b0);
    send_item(REQ_BYTE, HDR_CHR_1, 1'b0);
    send_item(REQ_BYTE, HDR_CHR_2, 1'b0);
    send_item(REQ_BYTE, 8'h32, 1'b0);
  endtask

  task automatic test_length_limits();
    send_frame(0, FLAW_HEX, 0, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b0);
    send_frame(MAX_LEN + 1, FLAW_NONE, 0, 1'b0);
  endtask

  task automatic test_bad_trailer();
    send_frame(1, FLAW_TRAILER, 0, 1'b0);
  endtask

  task automatic test_bad_header_prefix();
    send_item(REQ_BYTE, HDR_CHR_0, 1'b0);
    send_item(REQ_BYTE, HDR_CHR_1, 1'b0);
    send_item(REQ_BYTE, HDR_CHR_2, 1'b0);
    send_item(REQ_BYTE, HDR_CHR_3, 1'b0);
  endtask

  task automatic test_timeout();
    write_timeout(16'd3);
    test_bad_header_prefix();
    repeat (3) send_item(REQ_TICK, 8'h00, 1'b0);
    write_timeout(16'd0);
    test_bad_header_prefix();
    send_item(REQ_TICK, 8'h00, 1'b0);
  endtask

  task automatic test_back_to_back();
    write_timeout(16'hFFFF);
    no_gaps = 1'b1;
    send_frame(2, FLAW_NONE, 0, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b0);
    send_frame(3, FLAW_NONE, 0, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_output_pressure();
    go_idle();
    no_gaps  = 1'b1;
    hold_len = 400;
    hold_req = 1'b1;
    send_frame(MAX_LEN, FLAW_NONE, 0, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b0);
    send_frame(MAX_LEN, FLAW_NONE, 0, 1'b0);
    send_item(REQ_BUSY, 8'h00, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [15:0] settings [5];
    int          target;
    int          r;
    int          len;
    settings = '{16'd1000, 16'hFFFF, 16'd24, 16'd6, 16'd1};
    foreach (settings[p]) begin
      write_timeout(settings[p]);
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        if (!rx_link) send_item(REQ_LINK, 8'($urandom), 1'b1);
        if (rx_busy && $urandom_range(0, 7) != 0) send_item(REQ_BUSY, 8'($urandom), 1'b0);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_LEN) : $urandom_range(0, 5);
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_frame(len, FLAW_NONE, TICK_ODDS, 1'b0);
        end else if (r < 65) begin
          send_frame(len, FLAW_HEADER, TICK_ODDS, 1'b0);
        end else if (r < 72) begin
          send_frame(len, FLAW_HEX, TICK_ODDS, 1'b0);
        end else if (r < 78) begin
          send_frame($urandom_range(MAX_LEN + 1, 255), FLAW_NONE, TICK_ODDS, 1'b0);
        end else if (r < 86) begin
          send_frame(len, FLAW_TRAILER, TICK_ODDS, 1'b0);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(req_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
          end
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = 16'd0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_BYTE;
    in_ch.data_byte  = 8'h00;
    in_ch.flag_value = 1'b0;
    no_gaps          = 1'b0;
    hold_req         = 1'b0;
    hold_len         = 0;
    items_sent       = 0;
    chars_checked    = 0;
    frames_emitted   = 0;
    mismatches       = 0;
    rx_busy          = 1'b0;
    rx_link          = 1'b0;
    rx_timeout       = TIMEOUT_RESET;
    rx_hdr           = '{default: 8'h00};
    clear_frame();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_good_frame();
    test_link_down();
    test_busy_byte();
    test_bad_header();
    test_length_limits();
    test_bad_trailer();
    test_timeout();
    test_back_to_back();
    test_output_pressure();
    test_random_traffic();

    go_idle();
    if (pending_chars.size() != 0) flag_mismatch("leftover epc_char count", 0,
                                                 pending_chars.size());
    $display("Run covered %0d input beats and %0d checked characters from %0d frames.",
             items_sent, chars_checked, frames_emitted);
    $display("Timeouts 0 to 65535, link and busy gating, broken frames, output hold-off.");
    if (mismatches == 0) begin
      $display("tb_epc_frame_receiver_top passed");
    end else begin
      $display("tb_epc_frame_receiver_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/efr_pkg.sv
hw/rtl/efr_if.sv
hw/rtl/efr_ctrl.sv
hw/rtl/efr_datapath.sv
hw/rtl/epc_frame_receiver_top.sv
sim/tb_epc_frame_receiver_top.sv
